[hdl/rse_pkg.sv]
`default_nettype none
package rse_pkg;

   localparam int DATA_W            = 32;
   localparam int STACK_DEPTH_DEF   = 16;
   localparam int FRACTION_BITS_DEF = 16;

   // token kind (req_tuser[0])
   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_OPER  = 1'b1;

   // operator codes (req_tuser[2:1])
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   // status codes (rsp_tuser)
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_UNDER   = 2'd1;
   localparam logic [1:0] ST_OVER    = 2'd2;
   localparam logic [1:0] ST_DIVZERO = 2'd3;

   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage
`default_nettype wire

[hdl/rse_ram.sv]
`default_nettype none
module rse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hdl/rse_div.sv]
`default_nettype none
module rse_div
   import rse_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DATA_W-1:0] left,
   input  wire logic [DATA_W-1:0] right,
   output logic      [DATA_W-1:0] quotient,
   output logic                   done
);

   // dividend is |left| scaled by 2^FRACTION_BITS, one quotient bit per cycle
   localparam int DW = DATA_W + FRACTION_BITS;
   localparam int CW = $clog2(DW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [DW-1:0]     num_ff, num_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] quo_ff, quo_in;

   logic [DATA_W-1:0] mag_l, mag_r;
   logic [DATA_W:0]   trial;
   logic              fits;
   logic              q_over_pos, q_over_neg;

   always_comb begin
      mag_l = left[DATA_W-1]  ? (~left + 1'b1)  : left;
      mag_r = right[DATA_W-1] ? (~right + 1'b1) : right;
      trial = {rem_ff, num_ff[DW-1]};
      fits  = trial >= {1'b0, den_ff};

      // magnitude above 2^31 - 1, or above 2^31 when the sign is negative
      q_over_pos = |num_ff[DW-1:DATA_W-1];
      q_over_neg = num_ff > DW'(SAT_MIN);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW);
         num_in  = DW'(mag_l) << FRACTION_BITS;
         rem_in  = '0;
         den_in  = mag_r;
         neg_in  = left[DATA_W-1] ^ right[DATA_W-1];
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - 1'b1;
            rem_in = fits ? DATA_W'(trial - {1'b0, den_ff}) : trial[DATA_W-1:0];
            num_in = {num_ff[DW-2:0], fits};
         end else begin
            // sign and saturate, truncation toward zero falls out of the magnitude form
            busy_in = 1'b0;
            done_in = 1'b1;
            if (!neg_ff) begin
               quo_in = q_over_pos ? SAT_MAX : num_ff[DATA_W-1:0];
            end else begin
               quo_in = q_over_neg ? SAT_MIN : (~num_ff[DATA_W-1:0] + 1'b1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

[hdl/rpn_stack_evaluator.sv]
// From an accepted token back to ready: push S_DECODE, S_DONE; add/subtract S_DECODE,
// S_CALC, S_DONE; multiply adds S_MUL, divide S_DIV (one quotient bit per cycle; Q16.16
// by default). Operator on a short stack S_DECODE, S_DONE; divide by zero S_DECODE, S_CALC,
// S_DONE. One token at a time: each operator needs the stack entry written by the token before.
// A result waits in an output register; the next expression is accepted meanwhile.
// Synchronous active-high reset empties the stack and clears the status; no clearing pass.
`default_nettype none
module rpn_stack_evaluator
   import rse_pkg::*;
#(
   parameter int STACK_DEPTH   = STACK_DEPTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // token channel
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,   // [31:0] value
   input  wire logic [2:0]        req_tuser,   // [0] cmd, [2:1] op
   input  wire logic              req_tlast,   // last token of the expression
   // result channel
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic      [DATA_W-1:0] rsp_tdata,   // [31:0] result
   output logic      [1:0]        rsp_tuser    // [1:0] status
);

   localparam int CW = $clog2(STACK_DEPTH + 1);   // count, 0..STACK_DEPTH
   localparam int AW = $clog2(STACK_DEPTH);       // RAM address

   // The top of stack lives in top_ff; the RAM holds the entries below it,
   // entry i at address i. An operator reads only the entry under the top.
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_CALC   = 6'b000100,
      S_MUL    = 6'b001000,
      S_DIV    = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type                state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [1:0]               err_ff, err_in;
   logic [DATA_W-1:0]        top_ff, top_in;
   logic signed [2*DATA_W-1:0] prod_ff, prod_in;

   // latched token
   logic                     tok_cmd_ff;
   logic [1:0]               tok_op_ff;
   logic [DATA_W-1:0]        tok_value_ff;
   logic                     tok_last_ff;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;

   // stack RAM
   logic                     ram_wr_en, ram_rd_en;
   logic [AW-1:0]            ram_wr_addr, ram_rd_addr;
   logic [DATA_W-1:0]        ram_rd_data;

   // divider
   logic                     div_start, div_done;
   logic [DATA_W-1:0]        div_quo;

   logic [CW-1:0]            cnt_m1, cnt_m2;
   logic [DATA_W:0]          sum_ext;
   logic [DATA_W-1:0]        sum_sat;
   logic signed [2*DATA_W-1:0] prod_shr;
   logic [DATA_W-1:0]        mul_sat;
   logic                     accept, out_free;

   function automatic logic [1:0] sticky(input logic [1:0] cur, input logic [1:0] code);
      sticky = (cur == ST_OK) ? code : cur;
   endfunction

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign cnt_m1   = count_ff - CW'(1);
   assign cnt_m2   = count_ff - CW'(2);

   // add / subtract with 33-bit headroom, left operand from RAM, right is the top
   always_comb begin
      if (tok_op_ff == OP_SUB) begin
         sum_ext = {ram_rd_data[DATA_W-1], ram_rd_data} - {top_ff[DATA_W-1], top_ff};
      end else begin
         sum_ext = {ram_rd_data[DATA_W-1], ram_rd_data} + {top_ff[DATA_W-1], top_ff};
      end
      if (sum_ext[DATA_W] != sum_ext[DATA_W-1]) begin
         sum_sat = sum_ext[DATA_W] ? SAT_MIN : SAT_MAX;
      end else begin
         sum_sat = sum_ext[DATA_W-1:0];
      end
   end

   // product rescale: arithmetic shift (floor), then clamp
   always_comb begin
      prod_shr = prod_ff >>> FRACTION_BITS;
      if ((&prod_shr[2*DATA_W-1:DATA_W-1]) || !(|prod_shr[2*DATA_W-1:DATA_W-1])) begin
         mul_sat = prod_shr[DATA_W-1:0];
      end else begin
         mul_sat = prod_shr[2*DATA_W-1] ? SAT_MIN : SAT_MAX;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      err_in        = err_ff;
      top_in        = top_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = cnt_m1[AW-1:0];
      ram_rd_en     = 1'b0;
      ram_rd_addr   = cnt_m2[AW-1:0];
      div_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (tok_cmd_ff == CMD_PUSH) begin
               if (count_ff >= CW'(STACK_DEPTH)) begin
                  err_in = sticky(err_ff, ST_OVER);
               end else begin
                  // old top sinks into the RAM
                  ram_wr_en = count_ff != '0;
                  top_in    = tok_value_ff;
                  count_in  = count_ff + 1'b1;
               end
               state_in = S_DONE;
            end else if (count_ff < CW'(2)) begin
               err_in   = sticky(err_ff, ST_UNDER);
               state_in = S_DONE;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = S_CALC;
            end
         end
         S_CALC: begin
            case (tok_op_ff)
               OP_ADD, OP_SUB: begin
                  top_in   = sum_sat;
                  count_in = cnt_m1;
                  state_in = S_DONE;
               end
               OP_MUL: begin
                  prod_in  = $signed(ram_rd_data) * $signed(top_ff);
                  state_in = S_MUL;
               end
               OP_DIV: begin
                  if (top_ff == '0) begin
                     top_in   = '0;
                     err_in   = sticky(err_ff, ST_DIVZERO);
                     count_in = cnt_m1;
                     state_in = S_DONE;
                  end else begin
                     div_start = 1'b1;
                     state_in  = S_DIV;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_MUL: begin
            top_in   = mul_sat;
            count_in = cnt_m1;
            state_in = S_DONE;
         end
         S_DIV: begin
            if (div_done) begin
               top_in   = div_quo;
               count_in = cnt_m1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!tok_last_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               // emit top and status (zero and underflow on an empty stack), then start a fresh expression
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_data_in   = '0;
                  rsp_status_in = sticky(err_ff, ST_UNDER);
               end else begin
                  rsp_data_in   = top_ff;
                  rsp_status_in = err_ff;
               end
               count_in = '0;
               err_in   = ST_OK;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff        <= top_in;
      prod_ff       <= prod_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      if (accept) begin
         tok_cmd_ff   <= req_tuser[0];
         tok_op_ff    <= req_tuser[2:1];
         tok_value_ff <= req_tdata;
         tok_last_ff  <= req_tlast;
      end
   end

   rse_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (top_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rse_div #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .left     (ram_rd_data),
      .right    (top_ff),
      .quotient (div_quo),
      .done     (div_done)
   );

   assign req_tready = state_ff == S_IDLE;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire

[hdl/rse_checker.sv]
`default_nettype none
module rse_checker
   import rse_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic [DATA_W-1:0] req_tdata,
   input wire logic [2:0]        req_tuser,
   input wire logic              req_tlast,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [DATA_W-1:0] rsp_tdata,
   input wire logic [1:0]        rsp_tuser
);

   logic unused_ok;
   assign unused_ok = ^{req_tdata, req_tuser, req_tlast};

   // reset leaves no result pending
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result pending after reset");

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   // one token at a time: ready drops after every accepted beat
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("token accepted while previous one in flight");

   // a new result comes only out of finishing a token
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a token in flight");

endmodule

bind rpn_stack_evaluator rse_checker u_rse_checker (.*);
`default_nettype wire
